>>> hw/rtl/chse_pkg.sv
`timescale 1ns / 1ps
// Shared constants, widths and helpers for the cubic Hermite spline evaluator.
// No dependencies.
package chse_pkg;

    localparam int DEF_MAX_KNOTS = 64;
    localparam int DEF_FRAC_BITS = 16;

    localparam int VAL_W      = 32;
    localparam int CALC_W     = 40;
    localparam int KNOT_IDX_W = 6;
    localparam int PARAM_S_W  = 22;
    localparam int SEG_W      = 6;
    localparam int S_DATA_W   = 224;
    localparam int M_DATA_W   = 192;
    localparam int ENTRY_W    = 6 * VAL_W;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [APB_AW-1:0] REG_SEGMENT_COUNT = 3'd0;
    localparam logic [SEG_W-1:0]  SEG_RESET         = 6'd1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    localparam logic signed [CALC_W-1:0] SAT_MAX = CALC_W'(64'sd2147483647);
    localparam logic signed [CALC_W-1:0] SAT_MIN = -CALC_W'(64'sd2147483648);

    function automatic logic [VAL_W-1:0] sat32(input logic signed [CALC_W-1:0] v);
        logic [VAL_W-1:0] r;
        if (v > SAT_MAX)
        begin
            r = SAT_MAX[VAL_W-1:0];
        end
        else if (v < SAT_MIN)
        begin
            r = SAT_MIN[VAL_W-1:0];
        end
        else
        begin
            r = v[VAL_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/chse_axis.sv
`timescale 1ns / 1ps
// One axis of the Hermite evaluator: coefficients and Horner chains, five stages.
// Depends on chse_pkg.
module chse_axis #(
    parameter int FRAC_BITS = chse_pkg::DEF_FRAC_BITS
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic [FRAC_BITS-1:0]            u_in,
    input  logic signed [chse_pkg::VAL_W-1:0] p0,
    input  logic signed [chse_pkg::VAL_W-1:0] p1,
    input  logic signed [chse_pkg::VAL_W-1:0] t0,
    input  logic signed [chse_pkg::VAL_W-1:0] t1,
    output logic [chse_pkg::VAL_W-1:0]      pos,
    output logic [chse_pkg::VAL_W-1:0]      tan
);
    import chse_pkg::*;

    localparam int W  = CALC_W;
    localparam int PW = CALC_W + FRAC_BITS + 1;

    function automatic logic signed [W-1:0] fl(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] sh;
        sh = v >>> FRAC_BITS;
        return sh[W-1:0];
    endfunction

    logic signed [W-1:0] p0e, p1e, t0e, t1e, d, a2_next, a3_next;

    logic [FRAC_BITS-1:0] u2_reg, u3_reg, u4_reg;
    logic signed [W-1:0]  p0_2_reg, t0_2_reg, a2_2_reg, a3_2_reg, a2x2_2_reg, a3x3_2_reg;
    logic signed [W-1:0]  p0_3_reg, t0_3_reg, a2_3_reg, a2x2_3_reg;
    logic signed [PW-1:0] m1_3_reg, mt1_3_reg;
    logic signed [W-1:0]  p0_4_reg, t0_4_reg;
    logic signed [PW-1:0] m2_4_reg, mt2_4_reg;
    logic signed [W-1:0]  p0_5_reg;
    logic signed [PW-1:0] m3_5_reg;
    logic [VAL_W-1:0]     tan_5_reg, pos_6_reg, tan_6_reg;

    logic signed [FRAC_BITS:0] su2, su3, su4;

    assign p0e = W'(p0);
    assign p1e = W'(p1);
    assign t0e = W'(t0);
    assign t1e = W'(t1);
    assign d       = p1e - p0e;
    assign a2_next = (d <<< 1) + d - (t0e <<< 1) - t1e;
    assign a3_next = t0e + t1e - (d <<< 1);

    assign su2 = $signed({1'b0, u2_reg});
    assign su3 = $signed({1'b0, u3_reg});
    assign su4 = $signed({1'b0, u4_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u2_reg     <= u_in;
            p0_2_reg   <= p0e;
            t0_2_reg   <= t0e;
            a2_2_reg   <= a2_next;
            a3_2_reg   <= a3_next;
            a2x2_2_reg <= a2_next <<< 1;
            a3x3_2_reg <= (a3_next <<< 1) + a3_next;

            u3_reg     <= u2_reg;
            p0_3_reg   <= p0_2_reg;
            t0_3_reg   <= t0_2_reg;
            a2_3_reg   <= a2_2_reg;
            a2x2_3_reg <= a2x2_2_reg;
            m1_3_reg   <= PW'(a3_2_reg) * PW'(su2);
            mt1_3_reg  <= PW'(a3x3_2_reg) * PW'(su2);

            u4_reg     <= u3_reg;
            p0_4_reg   <= p0_3_reg;
            t0_4_reg   <= t0_3_reg;
            m2_4_reg   <= PW'(a2_3_reg + fl(m1_3_reg)) * PW'(su3);
            mt2_4_reg  <= PW'(a2x2_3_reg + fl(mt1_3_reg)) * PW'(su3);

            p0_5_reg   <= p0_4_reg;
            m3_5_reg   <= PW'(t0_4_reg + fl(m2_4_reg)) * PW'(su4);
            tan_5_reg  <= sat32(t0_4_reg + fl(mt2_4_reg));

            pos_6_reg  <= sat32(p0_5_reg + fl(m3_5_reg));
            tan_6_reg  <= tan_5_reg;
        end
    end

    assign pos = pos_6_reg;
    assign tan = tan_6_reg;

endmodule

>>> hw/rtl/cubic_hermite_spline_eval_unit.sv
`timescale 1ns / 1ps
// Cubic Hermite spline evaluator top level: knot memory, APB register, pipeline control.
// Depends on chse_pkg and chse_axis.
//
// Takes one item per clock while the output side keeps up. A load item writes one knot
// (position and tangent, all three axes) into a dual-read knot memory and gives no result.
// An evaluate item reads knots k and k+1 through the memory's two read ports and passes
// through registered stages after it is accepted: the memory read, the coefficients,
// the dependent multiplies of the Horner chain, and the final add and saturation. A held
// output stalls the whole pipeline.
// Evaluations at or past segment_count return the final knot with the end flag set.
// Knots must be loaded before they are evaluated; the memory has no clearing pass.
module cubic_hermite_spline_eval_unit #(
    parameter int MAX_KNOTS = chse_pkg::DEF_MAX_KNOTS,
    parameter int FRAC_BITS = chse_pkg::DEF_FRAC_BITS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // knot_index, knot_pos_x, knot_pos_y, knot_pos_z, knot_tan_x, knot_tan_y,
    // knot_tan_z, param_s, zero pad
    input  logic [chse_pkg::S_DATA_W-1:0]    s_tdata,
    // opcode
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // out_pos_x, out_pos_y, out_pos_z, out_tan_x, out_tan_y, out_tan_z
    output logic [chse_pkg::M_DATA_W-1:0]    m_tdata,
    // end flag: param_s at or past the final knot
    output logic                             m_tuser,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [chse_pkg::APB_AW-1:0]      paddr,
    input  logic [chse_pkg::APB_DW-1:0]      pwdata,
    output logic [chse_pkg::APB_DW-1:0]      prdata,
    output logic                             pready
);
    import chse_pkg::*;

    localparam int AW   = (MAX_KNOTS > 2) ? $clog2(MAX_KNOTS) : 1;
    localparam int KW   = (PARAM_S_W > FRAC_BITS) ? (PARAM_S_W - FRAC_BITS) : 1;
    localparam int IW0  = (KW > AW) ? KW : AW;
    localparam int IW   = ((IW0 > SEG_W) ? IW0 : SEG_W) + 1;
    localparam int NSTG = 6;
    localparam int SXW  = PARAM_S_W + FRAC_BITS;

    logic [SEG_W-1:0] seg_reg;
    logic             en, accept;
    logic [NSTG-1:0]  vld_reg;
    logic [NSTG-1:0]  last_reg;

    logic [ENTRY_W-1:0] mem [MAX_KNOTS];
    logic [ENTRY_W-1:0] rd_a_reg, rd_b_reg, rd_a, rd_b;
    logic               zero_a_reg, zero_b_reg;
    logic [FRAC_BITS-1:0] u1_reg;

    logic [SXW-1:0]       s_ext;
    logic [KW-1:0]        k;
    logic [FRAC_BITS-1:0] u;
    logic [IW-1:0]        kx, nx, idx_a, idx_b, load_idx;
    logic                 clamp, is_eval, is_load;
    logic [ENTRY_W-1:0]   wr_entry;

    assign pready = 1'b1;
    always_comb
    begin
        prdata = '0;
        if (paddr == REG_SEGMENT_COUNT)
        begin
            prdata = APB_DW'(seg_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg <= SEG_RESET;
        end
        else if (psel && penable && pwrite && pready && paddr == REG_SEGMENT_COUNT)
        begin
            seg_reg <= pwdata[SEG_W-1:0];
        end
    end

    assign en       = !vld_reg[NSTG-1] || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && en;
    assign is_eval  = s_tuser == OP_EVAL;
    assign is_load  = s_tuser == OP_LOAD;

    assign s_ext    = {{FRAC_BITS{1'b0}}, s_tdata[219:198]};
    assign k        = KW'(s_ext >> FRAC_BITS);
    assign u        = s_ext[FRAC_BITS-1:0];
    assign kx       = IW'(k);
    assign nx       = IW'(seg_reg);
    assign clamp    = kx >= nx;
    assign idx_a    = clamp ? nx : kx;
    assign idx_b    = kx + IW'(1);
    assign load_idx = IW'(s_tdata[5:0]);
    assign wr_entry = s_tdata[197:6];

    always_ff @(posedge clk)
    begin
        if (accept && is_load && load_idx < IW'(MAX_KNOTS))
        begin
            mem[load_idx[AW-1:0]] <= wr_entry;
        end
        if (en)
        begin
            rd_a_reg   <= mem[idx_a[AW-1:0]];
            rd_b_reg   <= mem[idx_b[AW-1:0]];
            zero_a_reg <= idx_a >= IW'(MAX_KNOTS);
            zero_b_reg <= idx_b >= IW'(MAX_KNOTS);
            u1_reg     <= clamp ? '0 : u;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            last_reg <= '0;
        end
        else if (en)
        begin
            vld_reg  <= {vld_reg[NSTG-2:0], accept && is_eval};
            last_reg <= {last_reg[NSTG-2:0], clamp};
        end
    end

    assign rd_a = zero_a_reg ? '0 : rd_a_reg;
    assign rd_b = zero_b_reg ? '0 : rd_b_reg;

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_axis
            chse_axis #(
                .FRAC_BITS(FRAC_BITS)
            ) u_axis (
                .clk  (clk),
                .en   (en),
                .u_in (u1_reg),
                .p0   ($signed(rd_a[g*VAL_W +: VAL_W])),
                .p1   ($signed(rd_b[g*VAL_W +: VAL_W])),
                .t0   ($signed(rd_a[(g+3)*VAL_W +: VAL_W])),
                .t1   ($signed(rd_b[(g+3)*VAL_W +: VAL_W])),
                .pos  (m_tdata[g*VAL_W +: VAL_W]),
                .tan  (m_tdata[(g+3)*VAL_W +: VAL_W])
            );
        end
    endgenerate

    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tuser  = last_reg[NSTG-1];

endmodule

>>> verif/chse_checker.sv
`timescale 1ns / 1ps
// Checker for the cubic Hermite spline evaluator: watches both streams and the register
// port, predicts each evaluate result and compares it. Depends on chse_pkg.
module chse_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [chse_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                            s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [chse_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                            m_tuser,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [chse_pkg::APB_AW-1:0]     paddr,
    input  logic [chse_pkg::APB_DW-1:0]     pwdata,
    input  logic                            pready,
    output int                              fail_count,
    output int                              pending
);
    import chse_pkg::*;

    typedef struct packed {
        logic                 last;
        logic [M_DATA_W-1:0]  vals;
    } spline_point_t;

    logic [VAL_W-1:0] knot_tab [6][64];
    logic [SEG_W-1:0] seg_cnt;
    spline_point_t    point_q[$];

    function automatic longint floor_q(longint v);
        return v >>> DEF_FRAC_BITS;
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return v[31:0];
    endfunction

    function automatic longint knot_val(int tab, int idx);
        if (idx >= 64) return 0;
        return longint'($signed(knot_tab[tab][idx]));
    endfunction

    function automatic spline_point_t eval_point(logic [PARAM_S_W-1:0] s);
        spline_point_t r;
        int k;
        longint u, p0, p1, t0, t1, a2, a3, h;
        k = s >> DEF_FRAC_BITS;
        u = s[DEF_FRAC_BITS-1:0];
        r.last = (k >= seg_cnt);
        for (int ax = 0; ax < 3; ax++)
        begin
            if (r.last)
            begin
                r.vals[ax*32 +: 32] = clamp32(knot_val(ax, seg_cnt));
                r.vals[(ax+3)*32 +: 32] = clamp32(knot_val(ax+3, seg_cnt));
            end
            else
            begin
                p0 = knot_val(ax, k);
                p1 = knot_val(ax, k+1);
                t0 = knot_val(ax+3, k);
                t1 = knot_val(ax+3, k+1);
                a2 = 3*(p1-p0) - 2*t0 - t1;
                a3 = 2*(p0-p1) + t0 + t1;
                h = a2 + floor_q(u*a3);
                h = t0 + floor_q(u*h);
                r.vals[ax*32 +: 32] = clamp32(p0 + floor_q(u*h));
                h = 2*a2 + floor_q(u*(3*a3));
                r.vals[(ax+3)*32 +: 32] = clamp32(t0 + floor_q(u*h));
            end
        end
        return r;
    endfunction

    assign pending = point_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        spline_point_t e;
        if (!rst_n)
        begin
            seg_cnt <= SEG_RESET;
            fail_count <= 0;
            point_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == REG_SEGMENT_COUNT)
                seg_cnt <= pwdata[SEG_W-1:0];
            if (m_tvalid && m_tready)
            begin
                if (point_q.size() == 0)
                begin
                    $display("%0t unexpected item: got %h/%b", $time, m_tdata, m_tuser);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = point_q.pop_front();
                    if (e.vals !== m_tdata || e.last !== m_tuser)
                    begin
                        $display("%0t mismatch: expected %h/%b got %h/%b",
                                 $time, e.vals, e.last, m_tdata, m_tuser);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == OP_LOAD)
                begin
                    for (int f = 0; f < 6; f++)
                        knot_tab[f][s_tdata[5:0]] = s_tdata[6 + f*32 +: 32];
                end
                else
                    point_q.push_back(eval_point(s_tdata[198 +: PARAM_S_W]));
            end
        end
    end
endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Top of the spline evaluator testbench: clock, reset, stimulus and verdict.
// Depends on chse_pkg, chse_checker and cubic_hermite_spline_eval_unit.
module testbench;
    import chse_pkg::*;

    logic                 clk, rst_n;
    logic                 s_tvalid, s_tready, s_tuser;
    logic [S_DATA_W-1:0]  s_tdata;
    logic                 m_tvalid, m_tready, m_tuser;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 psel, penable, pwrite, pready;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata, prdata;
    int                   fail_count, pending;
    int                   cycle_cnt;
    bit                   stim_done;
    int                   n_seg;

    cubic_hermite_spline_eval_unit uut (.*);
    chse_checker chk (.*);

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    function automatic logic [31:0] rand_val();
        case ($urandom_range(0, 5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 255) << 16;
            3: return -($urandom_range(0, 255) << 16);
            default: return $urandom;
        endcase
    endfunction

    task automatic send(logic op, logic [5:0] idx, logic [PARAM_S_W-1:0] s);
        logic [S_DATA_W-1:0] d;
        int gap;
        d = '0;
        d[5:0] = idx;
        for (int f = 0; f < 6; f++)
            d[6 + f*32 +: 32] = rand_val();
        d[198 +: PARAM_S_W] = s;
        gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= d;
        s_tuser <= op;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic set_segments(int n);
        s_tvalid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        psel <= 1; pwrite <= 1; paddr <= REG_SEGMENT_COUNT; pwdata <= n;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        n_seg = n;
    endtask

    // s with a chosen segment; sometimes past the end
    function automatic logic [PARAM_S_W-1:0] pick_s();
        int k;
        k = ($urandom_range(0, 7) == 0) ? $urandom_range(n_seg, 63) : $urandom_range(0, n_seg-1);
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? 22'h3fffff : 22'h0;
        return PARAM_S_W'((k << 16) | $urandom_range(0, 65535));
    endfunction

    initial
    begin
        int segs[6];
        segs = '{1, 63, 2, 7, 20, 0};
        s_tvalid = 0; s_tdata = '0; s_tuser = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        rst_n = 0; n_seg = 1; stim_done = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        for (int i = 0; i < 64; i++)
            send(OP_LOAD, 6'(i), PARAM_S_W'($urandom));
        // directed: segment 0, end, fractions at extremes, clamp
        send(OP_EVAL, 0, 22'h0);
        send(OP_EVAL, 0, 22'h0ffff);
        send(OP_EVAL, 0, 22'h08000);
        send(OP_EVAL, 0, 22'h10000);
        send(OP_EVAL, 0, 22'h3fffff);
        foreach (segs[j])
        begin
            set_segments(segs[j]);
            send(OP_EVAL, 0, 22'h3fffff);
            send(OP_EVAL, 0, 22'h0);
            for (int i = 0; i < 130; i++)
            begin
                if ($urandom_range(0, 4) == 0)
                    send(OP_LOAD, 6'($urandom_range(0, 63)), PARAM_S_W'($urandom));
                else if (n_seg == 0)
                    send(OP_EVAL, 0, PARAM_S_W'($urandom));
                else
                    send(OP_EVAL, 0, pick_s());
            end
        end
        s_tvalid <= 0;
        @(posedge clk);
        stim_done = 1;
    end

    initial
    begin
        m_tready = 0;
        @(posedge rst_n);
        forever
        begin
            int w;
            w = $urandom_range(0, 17);
            if (w > 0)
            begin
                m_tready <= 0;
                repeat (w) @(posedge clk);
            end
            m_tready <= 1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    initial
    begin
        cycle_cnt = 0;
        while (!stim_done && cycle_cnt < 200000)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        while (pending != 0 && cycle_cnt < 200000)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        repeat (20) @(posedge clk);
        if (cycle_cnt >= 200000 || pending != 0)
            $display("[cubic_hermite_spline_eval_unit] ERROR");
        else if (fail_count == 0)
            $display("[cubic_hermite_spline_eval_unit] OK");
        else
            $display("[cubic_hermite_spline_eval_unit] ERROR");
        $finish;
    end
endmodule

>>> files.f
hw/rtl/chse_pkg.sv
hw/rtl/chse_axis.sv
hw/rtl/cubic_hermite_spline_eval_unit.sv
verif/chse_checker.sv
verif/testbench.sv
